>>> rtl/core/wwdf_pkg.sv
// Shared types, constants and a helper function of the whole-word deletion filter.
`default_nettype none

package wwdf_pkg;

    // Word buffer geometry
    localparam int MAX_WORD = 16;
    localparam int WORD_AW  = $clog2(MAX_WORD);
    localparam int CNT_W    = $clog2(MAX_WORD + 1);

    // Beat and register widths
    localparam int BYTE_W   = 8;
    localparam int DEL_W    = 16;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_W    = 5;
    localparam int TGT_W    = 2 * CFG_W;
    localparam int M_DATA_W = BYTE_W + DEL_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TGT_LEN  = 2'd2;

    // Reset values of the target word ("parola")
    localparam logic [CFG_W-1:0] TGT_LOW_RST  = 64'h0000_616C_6F72_6170;
    localparam logic [CFG_W-1:0] TGT_HIGH_RST = 64'h0;
    localparam logic [LEN_W-1:0] TGT_LEN_RST  = 5'd6;

    // Input command codes
    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_EOS  = 1'b1;

    localparam logic [DEL_W-1:0] DEL_MAX = '1;

    // One result beat
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              has_byte;
        logic              last;
        logic [DEL_W-1:0]  deletions;
    } out_beat_t;

    // Fixed separator set
    function automatic logic is_sep(input logic [BYTE_W-1:0] b);
        logic r;
        case (b) inside
            8'h20, 8'h09, 8'h0D, 8'h0A, 8'h2E, 8'h2C, 8'h3B, 8'h3A,
            8'h27, 8'h22, 8'h28, 8'h29, 8'h2D, 8'h60, 8'h2A, 8'h26,
            8'h5E, 8'h23, 8'h40, 8'h21, 8'h24, 8'h5C, 8'h7C, 8'h5B,
            8'h5D, 8'h7B, 8'h7D, 8'h2F, 8'h3F: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/wwdf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module wwdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/wwdf_obuf.sv
// Output register stage of the result channel.
`default_nettype none

module wwdf_obuf
    import wwdf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire out_beat_t push_beat,
    output logic           push_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_beat
);

    logic      valid_reg;
    out_beat_t beat_reg;

    assign push_ready = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign m_beat     = beat_reg;

    // Hold a beat until taken, load the next one in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push_ready) begin
            valid_reg <= push;
        end
        if (push && push_ready) begin
            beat_reg <= push_beat;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/wwdf_ctrl.sv
// Sequencer: buffers words in RAM, compares and flushes them on a separator, end of stream or overflow.
`default_nettype none

module wwdf_ctrl
    import wwdf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_cmd,
    input  wire logic [BYTE_W-1:0]    s_byte,
    output logic                      ram_we,
    output logic [WORD_AW-1:0]        ram_waddr,
    output logic [BYTE_W-1:0]         ram_wdata,
    output logic                      ram_re,
    output logic [WORD_AW-1:0]        ram_raddr,
    input  wire logic [BYTE_W-1:0]    ram_rdata,
    output logic                      push,
    output out_beat_t                 push_beat,
    input  wire logic                 push_ready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_EMIT_RD,
        ST_EMIT_PUSH,
        ST_TAIL
    } state_t;

    state_t             state_reg, state_next;
    logic [TGT_W-1:0]   target_reg, target_next;
    logic [LEN_W-1:0]   tlen_reg, tlen_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               overlong_reg, overlong_next;
    logic [DEL_W-1:0]   del_reg, del_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [WORD_AW-1:0] idx_reg, idx_next;
    logic [BYTE_W-1:0]  tail_byte_reg, tail_byte_next;
    logic               tail_has_reg, tail_has_next;
    logic               sep_tail_reg, sep_tail_next;

    logic               accept;
    logic               closing;
    logic               at_end;
    logic [BYTE_W-1:0]  tgt_byte;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign closing   = (s_cmd == CMD_EOS) || is_sep(s_byte);
    assign at_end    = ({1'b0, idx_reg} == CNT_W'(len_reg - CNT_W'(1)));
    assign tgt_byte  = target_reg[{idx_reg, 3'b000} +: BYTE_W];

    // Store a word byte at the fill position
    assign ram_we    = accept && !closing && !overlong_reg && (count_reg < CNT_W'(MAX_WORD));
    assign ram_waddr = count_reg[WORD_AW-1:0];
    assign ram_wdata = s_byte;
    assign ram_re    = (state_reg == ST_CMP_RD) || (state_reg == ST_EMIT_RD);
    assign ram_raddr = idx_reg;

    // Result beats: buffered bytes, or the closing tail beat
    always_comb begin
        push_beat.deletions = del_reg;
        if (state_reg == ST_TAIL) begin
            push              = 1'b1;
            push_beat.data    = tail_byte_reg;
            push_beat.has_byte = tail_has_reg;
            push_beat.last    = 1'b1;
        end else begin
            push              = (state_reg == ST_EMIT_PUSH);
            push_beat.data    = ram_rdata;
            push_beat.has_byte = 1'b1;
            push_beat.last    = at_end && !sep_tail_reg;
        end
    end

    // Next-state logic
    always_comb begin
        state_next     = state_reg;
        target_next    = target_reg;
        tlen_next      = tlen_reg;
        count_next     = count_reg;
        overlong_next  = overlong_reg;
        del_next       = del_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        tail_byte_next = tail_byte_reg;
        tail_has_next  = tail_has_reg;
        sep_tail_next  = sep_tail_reg;

        // Configuration writes
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_TGT_LOW:  target_next[CFG_W-1:0]     = cfg_wdata;
                CFG_TGT_HIGH: target_next[TGT_W-1:CFG_W] = cfg_wdata;
                CFG_TGT_LEN:  tlen_next = cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next = '0;
                    if (closing) begin
                        tail_byte_next = (s_cmd == CMD_EOS) ? '0 : s_byte;
                        tail_has_next  = (s_cmd != CMD_EOS);
                        sep_tail_next  = (s_cmd != CMD_EOS);
                        len_next       = count_reg;
                        count_next     = '0;
                        overlong_next  = 1'b0;
                        if (overlong_reg || count_reg == '0) begin
                            state_next = ST_TAIL;
                        end else if (LEN_W'(count_reg) == tlen_reg) begin
                            state_next = ST_CMP_RD;
                        end else begin
                            state_next = ST_EMIT_RD;
                        end
                    end else if (overlong_reg) begin
                        tail_byte_next = s_byte;
                        tail_has_next  = 1'b1;
                        sep_tail_next  = 1'b1;
                        state_next     = ST_TAIL;
                    end else if (count_reg < CNT_W'(MAX_WORD)) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        // Overflow: flush the buffer, then pass the new byte
                        tail_byte_next = s_byte;
                        tail_has_next  = 1'b1;
                        sep_tail_next  = 1'b1;
                        len_next       = count_reg;
                        count_next     = '0;
                        overlong_next  = 1'b1;
                        state_next     = ST_EMIT_RD;
                    end
                end
            end
            ST_CMP_RD: begin
                state_next = ST_CMP_CHK;
            end
            ST_CMP_CHK: begin
                if (ram_rdata != tgt_byte) begin
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end else if (at_end) begin
                    if (del_reg != DEL_MAX) begin
                        del_next = del_reg + DEL_W'(1);
                    end
                    state_next = ST_TAIL;
                end else begin
                    idx_next   = idx_reg + WORD_AW'(1);
                    state_next = ST_CMP_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_PUSH;
            end
            ST_EMIT_PUSH: begin
                if (push_ready) begin
                    if (at_end) begin
                        state_next = sep_tail_reg ? ST_TAIL : ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + WORD_AW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_TAIL: begin
                if (push_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            target_reg   <= {TGT_HIGH_RST, TGT_LOW_RST};
            tlen_reg     <= TGT_LEN_RST;
            count_reg    <= '0;
            overlong_reg <= 1'b0;
            del_reg      <= '0;
            len_reg      <= '0;
            idx_reg      <= '0;
            sep_tail_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            target_reg   <= target_next;
            tlen_reg     <= tlen_next;
            count_reg    <= count_next;
            overlong_reg <= overlong_next;
            del_reg      <= del_next;
            len_reg      <= len_next;
            idx_reg      <= idx_next;
            sep_tail_reg <= sep_tail_next;
        end
        tail_byte_reg <= tail_byte_next;
        tail_has_reg  <= tail_has_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/whole_word_deletion_filter.sv
// Top level of the whole-word deletion filter.
//
// Channel   Direction  Beat content
// s_*       in         tuser: command (1 = end of stream), tdata: text byte
// m_*       out        tuser: has_byte, tlast: last, tdata: out_byte, deletions
// cfg_*     in         register writes: 0 target low, 1 target high, 2 length
//
// A separator or end of stream is accepted, then a word of target length is compared
// byte by byte up to the first differing byte, in a read and a check state each, as the
// word RAM read is registered; released bytes take a read and a push state each, then
// the closing beat, which end of stream skips once bytes were released. An overflowing
// byte flushes the buffer this way, then passes. Reset is synchronous, active low, and
// needs no clearing pass. A stalled m_ channel holds the sequencer.
`default_nettype none

module whole_word_deletion_filter
    import wwdf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
    input  wire logic                 s_tuser,   // [0] command
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,   // [7:0] out_byte, [23:8] deletions
    output logic                      m_tuser,   // [0] has_byte
    output logic                      m_tlast,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    logic               ram_we;
    logic [WORD_AW-1:0] ram_waddr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [WORD_AW-1:0] ram_raddr;
    logic [BYTE_W-1:0]  ram_rdata;
    logic               push;
    logic               push_ready;
    out_beat_t          push_beat;
    out_beat_t          m_beat;

    wwdf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_WORD)
    ) u_word_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    wwdf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_cmd      (s_tuser),
        .s_byte     (s_tdata),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .push       (push),
        .push_beat  (push_beat),
        .push_ready (push_ready)
    );

    wwdf_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_beat  (push_beat),
        .push_ready (push_ready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_beat     (m_beat)
    );

    // Pack the result beat
    assign m_tdata = {m_beat.deletions, m_beat.data};
    assign m_tuser = m_beat.has_byte;
    assign m_tlast = m_beat.last;

endmodule

`default_nettype wire

>>> rtl/core/wwdf_chk.sv
// Port-level checker of the whole-word deletion filter, bound to the top level.
`default_nettype none

module wwdf_chk
    import wwdf_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                s_tuser,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tuser,
    input wire logic                m_tlast
);

    // A stalled result beat holds its payload
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // An empty beat only closes an end of stream and carries no byte
    a_empty_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata[BYTE_W-1:0] == '0))
        else $error("empty beat not final or not zero");

    // The deletion count never goes down between visible beats
    a_del_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && $past(m_tvalid) |->
            m_tdata[M_DATA_W-1:BYTE_W] >= $past(m_tdata[M_DATA_W-1:BYTE_W]))
        else $error("deletion count decreased");

    // End of stream always produces a result, so the input closes
    a_eos_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input still open after end of stream");

endmodule

bind whole_word_deletion_filter wwdf_chk u_wwdf_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
